FILE: rtl/core/dbpps_pkg.sv
`timescale 1ns / 1ps

package dbpps_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;

    // mode codes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_WRITE  = 3'd1;
    localparam logic [2:0] MODE_COMMIT = 3'd2;
    localparam logic [2:0] MODE_START  = 3'd3;
    localparam logic [2:0] MODE_STOP   = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BUSY   = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_IDLE   = 3'd3;
    localparam logic [2:0] ST_BADIDX = 3'd4;

    // power-up contents of set A
    localparam int          DEF_SLOTS    = 4;
    localparam logic [15:0] DEF_DUR_HIGH = 16'd10;
    localparam logic [15:0] DEF_DUR_LOW  = 16'd20;
    localparam logic [2:0]  DEF_PAT_HIGH = 3'h7;
    localparam logic [2:0]  DEF_PAT_LOW  = 3'h0;

    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  entry_index;
        logic [15:0] duration;
        logic [2:0]  pin_pattern;
        logic [7:0]  commit_len;
    } t_in;

    typedef struct packed {
        logic [2:0] pins;
        logic       running;
        logic       active_bank;
        logic [5:0] position;
        logic [2:0] status;
    } t_out;

    typedef struct packed {
        logic [15:0] dur;
        logic [2:0]  pat;
    } t_seg;

    // even default slots drive high for the short time, odd ones low for the long time
    function automatic t_seg seg_default(input logic odd);
        t_seg s;
        s.dur = odd ? DEF_DUR_LOW : DEF_DUR_HIGH;
        s.pat = odd ? DEF_PAT_LOW : DEF_PAT_HIGH;
        return s;
    endfunction

endpackage

FILE: rtl/core/dbpps_seg_mem.sv
`timescale 1ns / 1ps

module dbpps_seg_mem
    import dbpps_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [$clog2(2*MAX_SEGMENTS)-1:0] i_wr_addr,
    input  t_seg                              i_wr_data,
    input  logic [$clog2(2*MAX_SEGMENTS)-1:0] i_rd_addr,
    output t_seg                              o_seg
);

    localparam int DEPTH = 2 * MAX_SEGMENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NDEF  = (MAX_SEGMENTS < DEF_SLOTS) ? MAX_SEGMENTS : DEF_SLOTS;

    t_seg             mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_seg             r_rd_data;
    logic             r_rd_hit;
    logic [AW-1:0]    r_rd_addr;
    logic             wr_fwd;

    assign wr_fwd = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (wr_fwd) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_hit  <= 1'b0;
            r_rd_addr <= '0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_hit  <= wr_fwd || r_valid[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // unwritten entries read as their power-up contents
    always_comb begin
        if (r_rd_hit) begin
            o_seg = r_rd_data;
        end else if (32'(r_rd_addr) < NDEF) begin
            o_seg = seg_default(r_rd_addr[0]);
        end else begin
            o_seg = '0;
        end
    end

endmodule

FILE: rtl/core/dbpps_ctrl.sv
`timescale 1ns / 1ps

module dbpps_ctrl
    import dbpps_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  t_in                               i_item,
    input  t_seg                              i_seg,
    output logic                              o_wr_en,
    output logic [$clog2(2*MAX_SEGMENTS)-1:0] o_wr_addr,
    output t_seg                              o_wr_data,
    output logic [$clog2(2*MAX_SEGMENTS)-1:0] o_rd_addr,
    output t_out                              o_result
);

    localparam int AW   = $clog2(2 * MAX_SEGMENTS);
    localparam int LW   = $clog2(MAX_SEGMENTS + 1);
    localparam int PW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int NDEF = (MAX_SEGMENTS < DEF_SLOTS) ? MAX_SEGMENTS : DEF_SLOTS;

    logic [LW-1:0] r_len [2];
    logic          r_active;
    logic          r_swap;
    logic          r_running;
    logic [PW-1:0] r_next;
    logic [15:0]   r_ticks;
    logic [2:0]    r_pins;

    logic [LW-1:0] n_len [2];
    logic          n_active;
    logic          n_swap;
    logic          n_running;
    logic [PW-1:0] n_next;
    logic [15:0]   n_ticks;
    logic [2:0]    n_pins;
    logic [2:0]    status;

    // segment lookup for the current state: wrap, then swap at pass start
    logic [PW-1:0] cur_pos;
    logic          cur_set;
    logic [LW-1:0] cur_len;
    logic [LW-1:0] pos_inc;
    logic          shadow;

    assign shadow  = ~r_active;
    assign cur_pos = (LW'(r_next) >= r_len[r_active]) ? '0 : r_next;
    assign cur_set = (cur_pos == '0 && r_swap) ? ~r_active : r_active;
    assign cur_len = r_len[cur_set];
    assign pos_inc = LW'(cur_pos) + LW'(1);

    always_comb begin
        n_len[0]  = r_len[0];
        n_len[1]  = r_len[1];
        n_active  = r_active;
        n_swap    = r_swap;
        n_running = r_running;
        n_next    = r_next;
        n_ticks   = r_ticks;
        n_pins    = r_pins;
        status    = ST_OK;
        o_wr_en   = 1'b0;
        o_wr_addr = shadow ? AW'(MAX_SEGMENTS) + AW'(i_item.entry_index)
                           : AW'(i_item.entry_index);
        o_wr_data.dur = i_item.duration;
        o_wr_data.pat = i_item.pin_pattern;
        if (i_fire) begin
            case (i_item.mode)
                MODE_TICK: begin
                    if (r_running) begin
                        if (r_ticks != '0) begin
                            n_ticks = r_ticks - 16'd1;
                        end else begin
                            n_next   = cur_pos;
                            n_active = cur_set;
                            if (cur_pos == '0 && r_swap) begin
                                n_swap = 1'b0;
                            end
                            if (cur_len != '0) begin
                                n_pins  = i_seg.pat;
                                n_ticks = (i_seg.dur == '0) ? '0 : i_seg.dur - 16'd1;
                                n_next  = (pos_inc >= cur_len) ? '0 : PW'(pos_inc);
                            end
                        end
                    end
                end
                MODE_WRITE: begin
                    if (32'(i_item.entry_index) >= 32'(MAX_SEGMENTS)) begin
                        status = ST_BADIDX;
                    end else begin
                        o_wr_en = 1'b1;
                    end
                end
                MODE_COMMIT: begin
                    n_len[shadow] = (32'(i_item.commit_len) > 32'(MAX_SEGMENTS))
                                  ? LW'(MAX_SEGMENTS) : LW'(i_item.commit_len);
                    n_swap = 1'b1;
                end
                MODE_START: begin
                    if (r_running) begin
                        status = ST_BUSY;
                    end else if (r_len[r_active] == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        n_running = 1'b1;
                        n_next    = '0;
                        n_ticks   = '0;
                    end
                end
                MODE_STOP: begin
                    if (!r_running) begin
                        status = ST_IDLE;
                    end else begin
                        n_running = 1'b0;
                        n_pins    = '0;
                        n_next    = '0;
                        n_ticks   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // prefetch the segment the following tick would load
    logic [PW-1:0] nx_pos;
    logic          nx_set;

    assign nx_pos    = (LW'(n_next) >= n_len[n_active]) ? '0 : n_next;
    assign nx_set    = (nx_pos == '0 && n_swap) ? ~n_active : n_active;
    assign o_rd_addr = nx_set ? AW'(MAX_SEGMENTS) + AW'(nx_pos) : AW'(nx_pos);

    assign o_result.pins        = n_pins;
    assign o_result.running     = n_running;
    assign o_result.active_bank = n_active;
    assign o_result.position    = 6'(n_next);
    assign o_result.status      = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len[0]  <= LW'(NDEF);
            r_len[1]  <= '0;
            r_active  <= 1'b0;
            r_swap    <= 1'b0;
            r_running <= 1'b0;
            r_next    <= '0;
            r_ticks   <= '0;
            r_pins    <= '0;
        end else begin
            r_len[0]  <= n_len[0];
            r_len[1]  <= n_len[1];
            r_active  <= n_active;
            r_swap    <= n_swap;
            r_running <= n_running;
            r_next    <= n_next;
            r_ticks   <= n_ticks;
            r_pins    <= n_pins;
        end
    end

endmodule

FILE: rtl/core/double_buffered_pin_pattern_sequencer.sv
`timescale 1ns / 1ps
// Path: an accepted input transaction passes through the input register, then the result
// register, from which its result can be taken. Throughput: one transaction per cycle
// while the result register is free or being drained; a held result stalls the input.
// The segment store is read ahead: its address is worked out from the next state.
// Reset (synchronous, active low) restores set A to its four power-up segments through
// per-entry valid bits; there is no clearing pass and inputs are taken right after reset.

module double_buffered_pin_pattern_sequencer
    import dbpps_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int AW = $clog2(2 * MAX_SEGMENTS);

    // input register stage
    logic          r_in_valid;
    t_in           r_in;
    // result register stage
    logic          r_out_valid;
    t_out          r_out;

    logic          fire;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_seg          wr_data;
    logic [AW-1:0] rd_addr;
    t_seg          seg;
    t_out          result;

    // the held item is processed once the result slot is free or being drained
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    dbpps_ctrl #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_in),
        .i_seg     (seg),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .o_result  (result)
    );

    dbpps_seg_mem #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_seg_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_seg     (seg)
    );

    // result register: holds a finished transaction until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
